// File: rtl/core/pdh_pkg.sv
// shared constants, types and codes of the pair distance histogram
package pdh_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int NUM_BINS      = 512;

    localparam int PW   = $clog2(MAX_PARTICLES);
    localparam int CW   = $clog2(MAX_PARTICLES + 1);
    localparam int BAW  = $clog2(NUM_BINS);
    localparam int SBW  = BAW + 1;

    localparam int COORD_W   = 24;
    localparam int LEN_W     = 23;
    localparam int DIV_W     = LEN_W + COORD_W - 1;
    localparam int MOD_STEPS = COORD_W;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 2;
    localparam int MD2_W     = 2 * LEN_W;
    localparam int BW_W      = 16;
    localparam int P_W       = SBW + BW_W;
    localparam int PSQ_W     = 2 * P_W;
    localparam int CMP_W     = (PSQ_W > D2_W) ? PSQ_W : D2_W;
    localparam int BIN_CELLS = SBW;

    localparam int FW       = 2 * PW + 1;
    localparam int CNT_W    = 48;
    localparam int FRM_W    = 32;
    localparam int IDX_W    = 10;
    localparam int FLIGHT_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] STATUS_FRAME   = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_READ    = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0] REG_BOX_X     = 3'd0;
    localparam logic [2:0] REG_BOX_Y     = 3'd1;
    localparam logic [2:0] REG_BOX_Z     = 3'd2;
    localparam logic [2:0] REG_BIN_WIDTH = 3'd3;
    localparam logic [2:0] REG_MIN_DIST  = 3'd4;

    typedef struct packed {
        logic          valid;
        logic [PW-1:0] i;
        logic [PW-1:0] j;
        logic          ci;
        logic          cj;
    } pdh_tag_t;

    typedef struct packed {
        pdh_tag_t                 tag;
        logic [2:0]               neg;
        logic [2:0][COORD_W-1:0]  rem;
        logic [2:0][DIV_W-1:0]    div;
    } pdh_mod_t;

    typedef struct packed {
        pdh_tag_t         tag;
        logic [D2_W-1:0]  d2;
        logic [SBW-1:0]   cand;
        logic [SBW-1:0]   step;
    } pdh_bin_t;

    typedef struct packed {
        logic                    cls;
        logic [2:0][COORD_W-1:0] pos;
    } pdh_part_t;

    typedef struct packed {
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] b;
        logic [CNT_W-1:0] a;
    } pdh_total_t;

    typedef struct packed {
        logic [FW-1:0] c;
        logic [FW-1:0] b;
        logic [FW-1:0] a;
    } pdh_frame_t;

endpackage

// File: rtl/core/pdh_mod_cell.sv
// one restoring step of the per-axis minimum-image remainder chain
module pdh_mod_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  pdh_pkg::pdh_mod_t cell_in,
    output pdh_pkg::pdh_mod_t cell_out
);

    pdh_pkg::pdh_mod_t out_reg;
    pdh_pkg::pdh_mod_t out_next;

    always_comb begin
        out_next = cell_in;
        for (int a = 0; a < 3; a++) begin
            if ({(pdh_pkg::DIV_W - pdh_pkg::COORD_W)'(0), cell_in.rem[a]} >= cell_in.div[a]) begin
                out_next.rem[a] = cell_in.rem[a] - cell_in.div[a][pdh_pkg::COORD_W-1:0];
            end
            // divisor moves one place down for the next cell
            out_next.div[a] = cell_in.div[a] >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg <= out_next;
        end
    end

    assign cell_out = out_reg;

endmodule

// File: rtl/core/pdh_bin_cell.sv
// one bit of the bin search: squares a trial bin edge and compares it to d2
module pdh_bin_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pdh_pkg::BW_W-1:0]   width,
    input  pdh_pkg::pdh_bin_t          cell_in,
    output pdh_pkg::pdh_bin_t          cell_out
);

    pdh_pkg::pdh_bin_t s1_reg;
    pdh_pkg::pdh_bin_t s2_reg;
    pdh_pkg::pdh_bin_t out_reg;
    pdh_pkg::pdh_bin_t out_next;
    logic [pdh_pkg::P_W-1:0]   prod_reg;
    logic [pdh_pkg::PSQ_W-1:0] sq_reg;
    logic [pdh_pkg::SBW-1:0]   trial;

    assign trial = cell_in.cand | cell_in.step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            out_reg <= '0;
        end else begin
            s1_reg  <= cell_in;
            s2_reg  <= s1_reg;
            out_reg <= out_next;
        end
        prod_reg <= {pdh_pkg::BW_W'(0), trial} * {pdh_pkg::SBW'(0), width};
        sq_reg   <= {pdh_pkg::P_W'(0), prod_reg} * {pdh_pkg::P_W'(0), prod_reg};
    end

    // trial edge squared not above d2 means the bin is at least the trial
    always_comb begin
        out_next = s2_reg;
        if (pdh_pkg::CMP_W'(sq_reg) <= pdh_pkg::CMP_W'(s2_reg.d2)) begin
            out_next.cand = s2_reg.cand | s2_reg.step;
        end
        out_next.step = s2_reg.step >> 1;
    end

    assign cell_out = out_reg;

endmodule

// File: rtl/core/pair_distance_histogram.sv
// Loads a frame of particles, bins all pair distances, keeps saturating histograms.
// A particle load is written to the particle memory on accept; a bin read holds off
// the input in the read state and registers its word into the result slot.
// A frame end runs pair issue from the particle memory read port, the cell chains
// and a merge sweep of the frame histogram into the running histogram.
// After reset a clearing pass over all NUM_BINS bins runs and no item is accepted.
module pair_distance_histogram (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // x_coord, y_coord, z_coord, class_zero, bin_select
    input  logic         s_tlast,
    input  logic [0:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // first_index, second_index, count_one_one,
                                    // count_zero_zero, count_mixed, frames_done
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_REF   = 4'd3;
    localparam logic [3:0] ST_PAIR  = 4'd4;
    localparam logic [3:0] ST_DRAIN = 4'd5;
    localparam logic [3:0] ST_SWEEP = 4'd6;
    localparam logic [3:0] ST_TAIL  = 4'd7;

    localparam logic [pdh_pkg::BAW-1:0] LAST_BIN = pdh_pkg::BAW'(pdh_pkg::NUM_BINS - 1);

    // configuration
    logic [pdh_pkg::LEN_W-1:0] box_x_reg, box_y_reg, box_z_reg, min_dist_reg;
    logic [pdh_pkg::BW_W-1:0]  bin_width_reg;
    logic [2:0][pdh_pkg::LEN_W-1:0] box_len;
    logic [pdh_pkg::BW_W-1:0]  w_eff;
    logic [pdh_pkg::MD2_W-1:0] md2_reg;

    // control
    logic [3:0] state_reg, state_next;
    logic [pdh_pkg::BAW-1:0] sweep_reg, sweep_next;
    logic [pdh_pkg::CW-1:0]  count_reg, count_next;
    logic [pdh_pkg::CW-1:0]  n_reg, n_next;
    logic [pdh_pkg::PW-1:0]  ii_reg, ii_next, jj_reg, jj_next;
    logic [pdh_pkg::FLIGHT_W-1:0] inflight_reg;
    logic [pdh_pkg::FRM_W-1:0] frame_cnt_reg;
    logic ovl_reg;
    logic [pdh_pkg::PW-1:0] ovl_i_reg, ovl_j_reg;
    logic pass_start;

    // input word fields
    logic s_acc;
    logic in_op, in_cls;
    logic [2:0][pdh_pkg::COORD_W-1:0] in_pos;
    logic [8:0]  in_bin;
    logic [15:0] sel16;
    logic [pdh_pkg::BAW-1:0] sel_addr;
    logic sel_ok, rd_ok_reg;

    // particle memory and pair front end
    pdh_pkg::pdh_part_t pmem [pdh_pkg::MAX_PARTICLES];
    pdh_pkg::pdh_part_t prd_reg, ref_reg;
    logic [pdh_pkg::PW-1:0] p_raddr;
    logic r_ref_reg, r_pair_reg;
    logic [pdh_pkg::PW-1:0] r_i_reg, r_j_reg;
    pdh_pkg::pdh_mod_t mod_link [pdh_pkg::MOD_STEPS+1];
    logic [2:0][pdh_pkg::COORD_W:0] diff;
    logic [2:0][pdh_pkg::COORD_W:0] dmag;

    // wrap fix, square, sum
    pdh_pkg::pdh_mod_t mod_last;
    pdh_pkg::pdh_tag_t fix_tag_reg, sq_tag_reg, d2_tag_reg;
    logic [2:0][pdh_pkg::COORD_W-1:0] fix_mag_reg;
    logic [2:0][pdh_pkg::COORD_W-1:0] fix_mag;
    logic [2:0][pdh_pkg::COORD_W-1:0] wr;
    logic [2:0][pdh_pkg::SQ_W-1:0] sq_reg;
    logic [pdh_pkg::D2_W-1:0] d2_reg;

    // bin search chain
    pdh_pkg::pdh_bin_t bin_link [pdh_pkg::BIN_CELLS+1];
    pdh_pkg::pdh_bin_t bo;
    logic bo_in_range;

    // frame histogram read-modify-write
    pdh_pkg::pdh_frame_t fmem [pdh_pkg::NUM_BINS];
    pdh_pkg::pdh_frame_t frd_reg, h_base, h_new, hw_val_reg;
    logic [pdh_pkg::BAW-1:0] f_raddr, h1_addr_reg, hw_addr_reg;
    logic h1_valid_reg, h1_hit_reg, h1_ci_reg, h1_cj_reg, hw_valid_reg;

    // running histogram
    pdh_pkg::pdh_total_t tmem [pdh_pkg::NUM_BINS];
    pdh_pkg::pdh_total_t trd_reg, t_sum;
    logic [pdh_pkg::BAW-1:0] t_raddr, sw_addr_reg;
    logic sw_valid_reg;

    // result slot
    logic m_valid_reg;
    logic [1:0] m_status_reg;
    logic [pdh_pkg::IDX_W-1:0] m_first_reg, m_second_reg;
    logic [pdh_pkg::CNT_W-1:0] m_a_reg, m_b_reg, m_c_reg;
    logic [pdh_pkg::FRM_W-1:0] m_frames_reg;
    logic [15:0] ovl_i_ext, ovl_j_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg     <= pdh_pkg::LEN_W'(655360);
            box_y_reg     <= pdh_pkg::LEN_W'(655360);
            box_z_reg     <= pdh_pkg::LEN_W'(655360);
            bin_width_reg <= pdh_pkg::BW_W'(655);
            min_dist_reg  <= pdh_pkg::LEN_W'(16384);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                pdh_pkg::REG_BOX_X:     box_x_reg     <= pwdata[pdh_pkg::LEN_W-1:0];
                pdh_pkg::REG_BOX_Y:     box_y_reg     <= pwdata[pdh_pkg::LEN_W-1:0];
                pdh_pkg::REG_BOX_Z:     box_z_reg     <= pwdata[pdh_pkg::LEN_W-1:0];
                pdh_pkg::REG_BIN_WIDTH: bin_width_reg <= pwdata[pdh_pkg::BW_W-1:0];
                pdh_pkg::REG_MIN_DIST:  min_dist_reg  <= pwdata[pdh_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            pdh_pkg::REG_BOX_X:     prdata = 32'(box_x_reg);
            pdh_pkg::REG_BOX_Y:     prdata = 32'(box_y_reg);
            pdh_pkg::REG_BOX_Z:     prdata = 32'(box_z_reg);
            pdh_pkg::REG_BIN_WIDTH: prdata = 32'(bin_width_reg);
            pdh_pkg::REG_MIN_DIST:  prdata = 32'(min_dist_reg);
            default:                prdata = 32'd0;
        endcase
    end

    assign box_len = {box_z_reg, box_y_reg, box_x_reg};
    assign w_eff   = (bin_width_reg == '0) ? pdh_pkg::BW_W'(1) : bin_width_reg;

    always_ff @(posedge aclk) begin
        md2_reg <= {pdh_pkg::LEN_W'(0), min_dist_reg} * {pdh_pkg::LEN_W'(0), min_dist_reg};
    end

    // ---------------- input word ----------------
    assign in_pos[0] = s_tdata[23:0];
    assign in_pos[1] = s_tdata[47:24];
    assign in_pos[2] = s_tdata[71:48];
    assign in_cls    = s_tdata[72];
    assign in_bin    = s_tdata[81:73];
    assign in_op     = s_tuser[0];

    assign sel16    = 16'(in_bin);
    assign sel_ok   = sel16 < 16'(pdh_pkg::NUM_BINS);
    assign sel_addr = sel16[pdh_pkg::BAW-1:0];

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        count_next = count_reg;
        n_next     = n_reg;
        ii_next    = ii_reg;
        jj_next    = jj_reg;
        pass_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BIN) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_op == pdh_pkg::OP_READ) begin
                        state_next = ST_READ;
                    end else begin
                        if (count_reg < pdh_pkg::CW'(pdh_pkg::MAX_PARTICLES)) begin
                            count_next = count_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            pass_start = 1'b1;
                            n_next     = count_next;
                            count_next = '0;
                            ii_next    = '0;
                            sweep_next = '0;
                            // zero or one particle: nothing to pair
                            state_next = (n_next < pdh_pkg::CW'(2)) ? ST_SWEEP : ST_REF;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_IDLE;
            end
            ST_REF: begin
                jj_next    = ii_reg + 1'b1;
                state_next = ST_PAIR;
            end
            ST_PAIR: begin
                if (pdh_pkg::CW'(jj_reg) == n_reg - 1'b1) begin
                    if (pdh_pkg::CW'(ii_reg) == n_reg - pdh_pkg::CW'(2)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        ii_next    = ii_reg + 1'b1;
                        state_next = ST_REF;
                    end
                end else begin
                    jj_next = jj_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (inflight_reg == '0) begin
                    sweep_next = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BIN) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
            count_reg <= '0;
            n_reg     <= '0;
            ii_reg    <= '0;
            jj_reg    <= '0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            ii_reg    <= ii_next;
            jj_reg    <= jj_next;
        end
    end

    // pairs issued minus pairs retired at the histogram stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + pdh_pkg::FLIGHT_W'(state_reg == ST_PAIR)
                                         - pdh_pkg::FLIGHT_W'(h1_valid_reg);
        end
    end

    // ---------------- particle memory ----------------
    assign p_raddr = (state_reg == ST_REF) ? ii_reg : jj_reg;

    always_ff @(posedge aclk) begin
        if (s_acc && in_op == pdh_pkg::OP_LOAD
                && count_reg < pdh_pkg::CW'(pdh_pkg::MAX_PARTICLES)) begin
            pmem[count_reg[pdh_pkg::PW-1:0]] <= '{cls: in_cls, pos: in_pos};
        end
        prd_reg <= pmem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_ref_reg  <= 1'b0;
            r_pair_reg <= 1'b0;
        end else begin
            r_ref_reg  <= state_reg == ST_REF;
            r_pair_reg <= state_reg == ST_PAIR;
        end
        r_i_reg <= ii_reg;
        r_j_reg <= jj_reg;
        if (r_ref_reg) begin
            ref_reg <= prd_reg;
        end
    end

    // displacement i minus j, split into sign and magnitude
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a] = {ref_reg.pos[a][pdh_pkg::COORD_W-1], ref_reg.pos[a]}
                    - {prd_reg.pos[a][pdh_pkg::COORD_W-1], prd_reg.pos[a]};
            dmag[a] = diff[a][pdh_pkg::COORD_W] ? (~diff[a] + 1'b1) : diff[a];
            mod_link[0].neg[a] = diff[a][pdh_pkg::COORD_W];
            mod_link[0].rem[a] = dmag[a][pdh_pkg::COORD_W-1:0];
            mod_link[0].div[a] = {box_len[a], (pdh_pkg::COORD_W - 1)'(0)};
        end
        mod_link[0].tag = '{valid: r_pair_reg, i: r_i_reg, j: r_j_reg,
                            ci: ref_reg.cls, cj: prd_reg.cls};
    end

    for (genvar g = 0; g < pdh_pkg::MOD_STEPS; g++) begin : g_mod
        pdh_mod_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (mod_link[g]),
            .cell_out (mod_link[g+1])
        );
    end

    assign mod_last = mod_link[pdh_pkg::MOD_STEPS];

    // remainder to minimum-image magnitude
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            wr[a] = (mod_last.neg[a] && mod_last.rem[a] != '0)
                  ? pdh_pkg::COORD_W'(box_len[a]) - mod_last.rem[a] : mod_last.rem[a];
            if (box_len[a] == '0) begin
                fix_mag[a] = mod_last.rem[a];
            end else if ({wr[a], 1'b0} > (pdh_pkg::COORD_W + 1)'(box_len[a])) begin
                fix_mag[a] = pdh_pkg::COORD_W'(box_len[a]) - wr[a];
            end else begin
                fix_mag[a] = wr[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fix_tag_reg <= '0;
            sq_tag_reg  <= '0;
            d2_tag_reg  <= '0;
        end else begin
            fix_tag_reg <= mod_last.tag;
            sq_tag_reg  <= fix_tag_reg;
            d2_tag_reg  <= sq_tag_reg;
        end
        fix_mag_reg <= fix_mag;
        for (int a = 0; a < 3; a++) begin
            sq_reg[a] <= {pdh_pkg::COORD_W'(0), fix_mag_reg[a]}
                       * {pdh_pkg::COORD_W'(0), fix_mag_reg[a]};
        end
        d2_reg     <= pdh_pkg::D2_W'(sq_reg[0]) + pdh_pkg::D2_W'(sq_reg[1])
                    + pdh_pkg::D2_W'(sq_reg[2]);
    end

    // first overlapping pair in issue order wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_reg <= 1'b0;
        end else if (pass_start) begin
            ovl_reg <= 1'b0;
        end else if (d2_tag_reg.valid && !ovl_reg
                     && d2_reg < pdh_pkg::D2_W'(md2_reg)) begin
            ovl_reg   <= 1'b1;
            ovl_i_reg <= d2_tag_reg.i;
            ovl_j_reg <= d2_tag_reg.j;
        end
    end

    // ---------------- bin search ----------------
    assign bin_link[0] = '{tag: d2_tag_reg, d2: d2_reg, cand: '0,
                           step: pdh_pkg::SBW'(1) << pdh_pkg::BAW};

    for (genvar g = 0; g < pdh_pkg::BIN_CELLS; g++) begin : g_bin
        pdh_bin_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .width    (w_eff),
            .cell_in  (bin_link[g]),
            .cell_out (bin_link[g+1])
        );
    end

    assign bo          = bin_link[pdh_pkg::BIN_CELLS];
    assign bo_in_range = bo.cand < pdh_pkg::SBW'(pdh_pkg::NUM_BINS);

    // ---------------- frame histogram ----------------
    assign f_raddr = (state_reg == ST_SWEEP) ? sweep_reg : bo.cand[pdh_pkg::BAW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_valid_reg <= 1'b0;
            h1_hit_reg   <= 1'b0;
            hw_valid_reg <= 1'b0;
        end else begin
            h1_valid_reg <= bo.tag.valid;
            h1_hit_reg   <= bo.tag.valid && bo_in_range;
            hw_valid_reg <= h1_valid_reg && h1_hit_reg;
        end
        h1_addr_reg <= bo.cand[pdh_pkg::BAW-1:0];
        h1_ci_reg   <= bo.tag.ci;
        h1_cj_reg   <= bo.tag.cj;
        hw_addr_reg <= h1_addr_reg;
        hw_val_reg  <= h_new;
    end

    // the write of the previous cycle is not yet in the read data
    always_comb begin
        h_base = (hw_valid_reg && hw_addr_reg == h1_addr_reg) ? hw_val_reg : frd_reg;
        h_new  = h_base;
        if (!h1_ci_reg && !h1_cj_reg) begin
            h_new.a = h_base.a + pdh_pkg::FW'(2);
        end else if (h1_ci_reg && h1_cj_reg) begin
            h_new.b = h_base.b + pdh_pkg::FW'(2);
        end else begin
            h_new.c = h_base.c + pdh_pkg::FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            fmem[sweep_reg] <= '0;
        end else if (sw_valid_reg) begin
            fmem[sw_addr_reg] <= '0;
        end else if (h1_valid_reg && h1_hit_reg) begin
            fmem[h1_addr_reg] <= h_new;
        end
        frd_reg <= fmem[f_raddr];
    end

    // ---------------- running histogram ----------------
    assign t_raddr = (state_reg == ST_SWEEP) ? sweep_reg : sel_addr;

    always_comb begin
        logic [pdh_pkg::CNT_W:0] sa, sb, sc;
        sa = {1'b0, trd_reg.a} + (pdh_pkg::CNT_W + 1)'(frd_reg.a);
        sb = {1'b0, trd_reg.b} + (pdh_pkg::CNT_W + 1)'(frd_reg.b);
        sc = {1'b0, trd_reg.c} + (pdh_pkg::CNT_W + 1)'(frd_reg.c);
        t_sum.a = sa[pdh_pkg::CNT_W] ? pdh_pkg::CNT_MAX : sa[pdh_pkg::CNT_W-1:0];
        t_sum.b = sb[pdh_pkg::CNT_W] ? pdh_pkg::CNT_MAX : sb[pdh_pkg::CNT_W-1:0];
        t_sum.c = sc[pdh_pkg::CNT_W] ? pdh_pkg::CNT_MAX : sc[pdh_pkg::CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_valid_reg <= 1'b0;
        end else begin
            sw_valid_reg <= state_reg == ST_SWEEP;
        end
        sw_addr_reg <= sweep_reg;
        if (state_reg == ST_CLEAR) begin
            tmem[sweep_reg] <= '0;
        end else if (sw_valid_reg && !ovl_reg) begin
            tmem[sw_addr_reg] <= t_sum;
        end
        trd_reg <= tmem[t_raddr];
        if (s_acc) begin
            rd_ok_reg <= sel_ok;
        end
    end

    // ---------------- result slot ----------------
    assign ovl_i_ext = 16'(ovl_i_reg);
    assign ovl_j_ext = 16'(ovl_j_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            frame_cnt_reg <= '0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_READ) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= pdh_pkg::STATUS_READ;
                m_first_reg  <= '0;
                m_second_reg <= '0;
                m_a_reg      <= rd_ok_reg ? trd_reg.a : '0;
                m_b_reg      <= rd_ok_reg ? trd_reg.b : '0;
                m_c_reg      <= rd_ok_reg ? trd_reg.c : '0;
                m_frames_reg <= frame_cnt_reg;
            end else if (state_reg == ST_TAIL) begin
                m_valid_reg <= 1'b1;
                m_a_reg     <= '0;
                m_b_reg     <= '0;
                m_c_reg     <= '0;
                if (ovl_reg) begin
                    m_status_reg <= pdh_pkg::STATUS_OVERLAP;
                    m_first_reg  <= ovl_i_ext[pdh_pkg::IDX_W-1:0];
                    m_second_reg <= ovl_j_ext[pdh_pkg::IDX_W-1:0];
                    m_frames_reg <= frame_cnt_reg;
                end else begin
                    m_status_reg <= pdh_pkg::STATUS_FRAME;
                    m_first_reg  <= '0;
                    m_second_reg <= '0;
                    if (frame_cnt_reg != '1) begin
                        frame_cnt_reg <= frame_cnt_reg + 1'b1;
                        m_frames_reg  <= frame_cnt_reg + 1'b1;
                    end else begin
                        m_frames_reg  <= frame_cnt_reg;
                    end
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, m_frames_reg, m_c_reg, m_b_reg, m_a_reg,
                       m_second_reg, m_first_reg};

    // ---------------- checks ----------------
    a_retire_has_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        h1_valid_reg |-> inflight_reg != '0)
        else $error("pair retired with no pair in flight");

    a_sweep_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> inflight_reg == '0 && !h1_valid_reg)
        else $error("histogram update during merge sweep");

    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL || state_reg == ST_READ) |-> !m_valid_reg)
        else $error("result written over a waiting word");

endmodule

// File: tb/sv/pdh_checker.sv
// checker for the pair distance histogram: predicts each result word and compares it
module pdh_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [87:0]  s_tdata,   // x_coord, y_coord, z_coord, class_zero, bin_select
    input  logic         s_tlast,
    input  logic [0:0]   s_tuser,   // operation
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,   // first_index, second_index, count_one_one,
                                    // count_zero_zero, count_mixed, frames_done
    input  logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                status;
        logic [9:0]                first;
        logic [9:0]                second;
        logic [pdh_pkg::CNT_W-1:0] a;
        logic [pdh_pkg::CNT_W-1:0] b;
        logic [pdh_pkg::CNT_W-1:0] c;
        logic [pdh_pkg::FRM_W-1:0] frames;
    } hist_word_t;

    hist_word_t expected_words[$];

    logic [pdh_pkg::LEN_W-1:0] box_len[3];
    logic [pdh_pkg::BW_W-1:0]  bin_w;
    logic [pdh_pkg::LEN_W-1:0] min_dist;

    logic signed [pdh_pkg::COORD_W-1:0] pos_mem[pdh_pkg::MAX_PARTICLES][3];
    logic                      cls_mem[pdh_pkg::MAX_PARTICLES];
    int unsigned               n_loaded;
    longint unsigned           frame_cnt[pdh_pkg::NUM_BINS][3];
    longint unsigned           total_cnt[pdh_pkg::NUM_BINS][3];
    longint unsigned           frames_acc;

    assign pending = expected_words.size();

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint min_image(longint d, longint len);
        longint r;
        if (len == 0) return d;
        r = d % len;
        if (r < 0) r += len;
        if (2 * r > len) r -= len;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // runs the pair pass over the loaded frame
    function automatic hist_word_t close_frame();
        hist_word_t w;
        longint unsigned md2, width, d2, bn, s;
        longint dd[3];
        w = '{default: '0};
        md2 = longint'(min_dist) * longint'(min_dist);
        width = (bin_w == 0) ? 1 : bin_w;
        foreach (frame_cnt[b, k]) frame_cnt[b][k] = 0;
        for (int i = 0; i < n_loaded; i++) begin
            for (int j = i + 1; j < n_loaded; j++) begin
                for (int k = 0; k < 3; k++)
                    dd[k] = min_image(longint'(pos_mem[i][k]) - longint'(pos_mem[j][k]),
                                      longint'(box_len[k]));
                d2 = dd[0] * dd[0] + dd[1] * dd[1] + dd[2] * dd[2];
                if (d2 < md2) begin
                    w.status = pdh_pkg::STATUS_OVERLAP;
                    w.first  = i[9:0];
                    w.second = j[9:0];
                    w.frames = frames_acc[31:0];
                    n_loaded = 0;
                    return w;
                end
                bn = int_sqrt(d2) / width;
                if (bn < pdh_pkg::NUM_BINS) begin
                    if (!cls_mem[i] && !cls_mem[j]) frame_cnt[bn][0] += 2;
                    else if (cls_mem[i] && cls_mem[j]) frame_cnt[bn][1] += 2;
                    else frame_cnt[bn][2] += 1;
                end
            end
        end
        foreach (total_cnt[b, k]) begin
            s = total_cnt[b][k] + frame_cnt[b][k];
            total_cnt[b][k] = (s > pdh_pkg::CNT_MAX) ? pdh_pkg::CNT_MAX : s;
        end
        if (frames_acc != 32'hFFFF_FFFF) frames_acc++;
        n_loaded = 0;
        w.status = pdh_pkg::STATUS_FRAME;
        w.frames = frames_acc[31:0];
        return w;
    endfunction

    initial begin
        errors = 0;
        box_len = '{655360, 655360, 655360};
        bin_w = 655;
        min_dist = 16384;
        n_loaded = 0;
        frames_acc = 0;
        foreach (total_cnt[b, k]) total_cnt[b][k] = 0;
    end

    always @(posedge aclk) begin
        hist_word_t w;
        logic [8:0] sel;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    errors++;
                end else begin
                    w = expected_words.pop_front();
                    if (m_tuser !== w.status) report_mismatch("status", m_tuser, w.status);
                    if (m_tdata[9:0] !== w.first)
                        report_mismatch("first_index", m_tdata[9:0], w.first);
                    if (m_tdata[19:10] !== w.second)
                        report_mismatch("second_index", m_tdata[19:10], w.second);
                    if (m_tdata[67:20] !== w.a)
                        report_mismatch("count_one_one", m_tdata[67:20], w.a);
                    if (m_tdata[115:68] !== w.b)
                        report_mismatch("count_zero_zero", m_tdata[115:68], w.b);
                    if (m_tdata[163:116] !== w.c)
                        report_mismatch("count_mixed", m_tdata[163:116], w.c);
                    if (m_tdata[195:164] !== w.frames)
                        report_mismatch("frames_done", m_tdata[195:164], w.frames);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == pdh_pkg::OP_READ) begin
                    w = '{default: '0};
                    sel = s_tdata[81:73];
                    w.status = pdh_pkg::STATUS_READ;
                    if (sel < pdh_pkg::NUM_BINS) begin
                        w.a = total_cnt[sel][0][pdh_pkg::CNT_W-1:0];
                        w.b = total_cnt[sel][1][pdh_pkg::CNT_W-1:0];
                        w.c = total_cnt[sel][2][pdh_pkg::CNT_W-1:0];
                    end
                    w.frames = frames_acc[31:0];
                    expected_words.push_back(w);
                end else begin
                    if (n_loaded < pdh_pkg::MAX_PARTICLES) begin
                        pos_mem[n_loaded][0] = s_tdata[23:0];
                        pos_mem[n_loaded][1] = s_tdata[47:24];
                        pos_mem[n_loaded][2] = s_tdata[71:48];
                        cls_mem[n_loaded] = s_tdata[72];
                        n_loaded++;
                    end
                    if (s_tlast) expected_words.push_back(close_frame());
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    pdh_pkg::REG_BOX_X:     box_len[0] = pwdata[pdh_pkg::LEN_W-1:0];
                    pdh_pkg::REG_BOX_Y:     box_len[1] = pwdata[pdh_pkg::LEN_W-1:0];
                    pdh_pkg::REG_BOX_Z:     box_len[2] = pwdata[pdh_pkg::LEN_W-1:0];
                    pdh_pkg::REG_BIN_WIDTH: bin_w = pwdata[pdh_pkg::BW_W-1:0];
                    pdh_pkg::REG_MIN_DIST:  min_dist = pwdata[pdh_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// top of the pair distance histogram testbench: clock, reset, stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 700;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         s_tlast = 0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [199:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           errors, pending;
    int           send_idle = 0, recv_stall = 0;
    int           cycles = 0;

    always #5 aclk = ~aclk;

    pair_distance_histogram DUT (.*);
    pdh_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(logic op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic cls, logic last, logic [8:0] sel);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {6'd0, sel, cls, z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load(logic [23:0] x, logic [23:0] y, logic [23:0] z, logic cls, logic last);
        send_word(pdh_pkg::OP_LOAD, x, y, z, cls, last, 9'($urandom));
    endtask

    task automatic read_bin(logic [8:0] sel);
        send_word(pdh_pkg::OP_READ, 24'($urandom), 24'($urandom), 24'($urandom),
                  1'($urandom), 1'($urandom), sel);
    endtask

    // hold off until every word has come back and the merge sweep is over
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 24'($urandom);
        return 24'($urandom_range(0, 327680));
    endfunction

    logic [31:0] settings[6][5] = '{
        '{655360, 655360, 655360, 655, 16384},
        '{1, 1, 1, 1, 0},
        '{8388607, 8388607, 8388607, 65535, 8388607},
        '{0, 0, 0, 0, 0},
        '{131072, 262144, 8388607, 3000, 0},
        '{655360, 524288, 393216, 1200, 4096}
    };

    initial begin
        int left, fsize;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed part under reset settings
        read_bin(9'd0);
        read_bin(9'd511);
        load(24'd1000, 24'd0, 24'd0, 1, 1);                  // single particle frame
        load(24'd0, 24'd0, 24'd0, 0, 0);
        load(24'd65536, 24'd0, 24'd0, 0, 0);
        load(24'd0, 24'd131072, 24'd0, 1, 0);
        load(24'd0, 24'd0, 24'd200000, 1, 1);
        load(24'h800000, 24'h7FFFFF, 24'h800000, 0, 0);      // coordinate extremes
        load(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1, 0);
        load(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 0, 1);
        load(24'd5000, 24'd5000, 24'd5000, 1, 0);            // overlapping pair
        load(24'd5100, 24'd5000, 24'd5000, 1, 1);
        read_bin(9'd100);
        read_bin(9'd155);
        read_bin(9'd200);
        drain();
        // store overflow: one load beyond capacity carries the frame end
        for (int i = 0; i <= pdh_pkg::MAX_PARTICLES; i++)
            load(24'd7, 24'd7, 24'd7, i[0], i == pdh_pkg::MAX_PARTICLES);
        drain();
        read_bin(9'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 5; r++) apb_write(3'(r), settings[p][r]);
            send_idle  = (p % 4 == 1) ? 67 : (p % 4 == 3) ? 13 : 0;
            recv_stall = (p % 4 == 2) ? 67 : (p % 4 == 3) ? 13 : 0;
            left = 0;
            for (int k = 0; k < 150; k++) begin
                if (left == 0 && $urandom_range(0, 3) == 0) begin
                    read_bin(($urandom_range(0, 3) == 0) ? 9'($urandom) :
                             9'($urandom_range(0, 40)));
                end else begin
                    if (left == 0) begin
                        fsize = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                            : $urandom_range(1, 8);
                        left = fsize;
                    end
                    left--;
                    load(rand_coord(), rand_coord(), rand_coord(), 1'($urandom), left == 0);
                end
            end
            if (left != 0) load(rand_coord(), rand_coord(), rand_coord(), 1'($urandom), 1);
            drain();
        end
        recv_stall = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
